### rtl/uat_pkg.sv
// Package for the undirected adjacency table: sizes, codes and shared types.
// No dependencies; every other file in rtl/ but uat_ram imports it.
package uat_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_DEGREE   = 16;

  localparam int VTX_W    = 6;
  localparam int WGT_W    = 32;
  localparam int STAT_W   = 3;
  localparam int FUNC_W   = 2;
  localparam int VCNT_W   = 7;
  localparam int CFG_AW   = 3;
  localparam int DEG_W    = $clog2(MAX_DEGREE + 1);
  localparam int SLOT_W   = $clog2(MAX_DEGREE);
  localparam int ENTRY_W  = VTX_W + WGT_W;
  localparam int NB_DEPTH = MAX_VERTICES * MAX_DEGREE;
  localparam int NB_AW    = $clog2(NB_DEPTH);

  localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(64);
  localparam logic [DEG_W-1:0]  DEG_FULL   = DEG_W'(MAX_DEGREE);

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD = 2'd0,
    FN_REM = 2'd1,
    FN_NBR = 2'd2
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_VERTEX = 3'd1,
    ST_SELF_LOOP  = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_FULL       = 3'd4
  } status_t;

  // register index = paddr[2]
  typedef enum logic [0:0] {
    REG_VERTEX_COUNT = 1'b0
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEG_A,
    S_DEG_B,
    S_ADD2,
    S_RM_START,
    S_RM_SCAN,
    S_RM_SHIFT,
    S_LIST,
    S_REPLY
  } state_t;

  function automatic logic vertex_ok(logic [VTX_W-1:0] v, logic [VCNT_W-1:0] cnt);
    return ({1'b0, v} < cnt) && (int'(v) < MAX_VERTICES);
  endfunction

endpackage

### rtl/uat_cmd_if.sv
// Command channel: valid/ready handshake with one command item as payload.
// Depends on uat_pkg.
interface uat_cmd_if import uat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [VTX_W-1:0]  first_vertex;
  logic [VTX_W-1:0]  second_vertex;
  logic signed [WGT_W-1:0] edge_weight;

  modport source (output valid, func, first_vertex, second_vertex, edge_weight,
                  input ready);
  modport sink   (input valid, func, first_vertex, second_vertex, edge_weight,
                  output ready);
endinterface

### rtl/uat_res_if.sv
// Result channel: valid/ready handshake with one result item as payload.
// Depends on uat_pkg.
interface uat_res_if import uat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              has_neighbor;
  logic [VTX_W-1:0]  neighbor_vertex;
  logic signed [WGT_W-1:0] neighbor_weight;
  logic              last_result;

  modport source (output valid, status, has_neighbor, neighbor_vertex,
                  neighbor_weight, last_result, input ready);
  modport sink   (input valid, status, has_neighbor, neighbor_vertex,
                  neighbor_weight, last_result, output ready);
endinterface

### rtl/uat_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module uat_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 38,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### rtl/uat_cfg.sv
// APB-style register port holding vertex_count.
// Depends on uat_pkg.
module uat_cfg import uat_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [VCNT_W-1:0] vertex_count
);
  logic sel_vcnt;

  assign pready   = 1'b1;
  assign sel_vcnt = (paddr[2] == REG_VERTEX_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCNT_RESET;
    end else if (psel && penable && pwrite && pready && sel_vcnt) begin
      vertex_count <= pwdata[VCNT_W-1:0];
    end
  end

  assign prdata = sel_vcnt ? {{(32-VCNT_W){1'b0}}, vertex_count} : 32'd0;
endmodule

### rtl/uat_ctrl.sv
// Command sequencer: degree/neighbor memory access, list search and shift,
// result register. Depends on uat_pkg, uat_cmd_if, uat_res_if.
module uat_ctrl import uat_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [VCNT_W-1:0] vertex_count,
  uat_cmd_if.sink           cmd,
  uat_res_if.source         res,
  // degree memory
  output logic              deg_we,
  output logic [VTX_W-1:0]  deg_waddr,
  output logic [DEG_W-1:0]  deg_wdata,
  output logic              deg_re,
  output logic [VTX_W-1:0]  deg_raddr,
  input  logic [DEG_W-1:0]  deg_rdata,
  // neighbor memory
  output logic              nb_we,
  output logic [NB_AW-1:0]  nb_waddr,
  output logic [ENTRY_W-1:0] nb_wdata,
  output logic              nb_re,
  output logic [NB_AW-1:0]  nb_raddr,
  input  logic [ENTRY_W-1:0] nb_rdata
);
  state_t state, state_next;

  func_t             func_r;
  logic [VTX_W-1:0]  va, vb;
  logic [WGT_W-1:0]  wt;
  logic [DEG_W-1:0]  deg_a, deg_b, slot;
  logic              side, miss;
  status_t           rstat;

  logic [MAX_VERTICES-1:0] dvalid;
  logic                    dvalid_q;

  logic              res_valid, res_has, res_last;
  status_t           res_status;
  logic [VTX_W-1:0]  res_peer;
  logic [WGT_W-1:0]  res_weight;

  logic              cmd_fire, out_free, in_bad, in_self;
  logic [DEG_W-1:0]  deg_now, cur_n, slot_inc;
  logic [VTX_W-1:0]  cur_u, cur_p, ent_peer;
  logic              more, match, list_last, add_full;
  logic              side_done, side_miss;
  logic              res_load;
  logic              ld_has, ld_last;
  status_t           ld_status;
  logic [VTX_W-1:0]  ld_peer;
  logic [WGT_W-1:0]  ld_weight;

  // shared conditions
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign out_free  = !res_valid || res.ready;
  assign in_self   = (cmd.first_vertex == cmd.second_vertex);
  assign deg_now   = dvalid_q ? deg_rdata : '0;
  assign cur_u     = side ? vb : va;
  assign cur_p     = side ? va : vb;
  assign cur_n     = side ? deg_b : deg_a;
  assign slot_inc  = slot + DEG_W'(1);
  assign more      = (slot_inc < cur_n);
  assign ent_peer  = nb_rdata[ENTRY_W-1:WGT_W];
  assign match     = (ent_peer == cur_p);
  assign list_last = (slot_inc == deg_a);
  assign add_full  = (deg_a >= DEG_FULL) || (deg_now >= DEG_FULL);

  always_comb begin
    if (func_t'(cmd.func) == FN_NBR) begin
      in_bad = !vertex_ok(cmd.first_vertex, vertex_count);
    end else begin
      in_bad = !vertex_ok(cmd.first_vertex, vertex_count) ||
               !vertex_ok(cmd.second_vertex, vertex_count);
    end
  end

  always_comb begin
    side_done = 1'b0;
    side_miss = 1'b0;
    case (state)
      S_RM_START: begin
        side_done = (cur_n == '0);
        side_miss = 1'b1;
      end
      S_RM_SCAN: begin
        side_done = !more;
        side_miss = !match;
      end
      S_RM_SHIFT: begin
        side_done = !more;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state) inside
      S_IDLE: begin
        if (cmd_fire) begin
          case (func_t'(cmd.func)) inside
            FN_ADD, FN_REM: state_next = (in_bad || in_self) ? S_REPLY : S_DEG_A;
            FN_NBR:         state_next = in_bad ? S_REPLY : S_DEG_A;
            default:        state_next = S_IDLE;
          endcase
        end
      end
      S_DEG_A: begin
        if (func_r == FN_NBR) begin
          state_next = (deg_now == '0) ? S_REPLY : S_LIST;
        end else begin
          state_next = S_DEG_B;
        end
      end
      S_DEG_B: begin
        if (func_r == FN_ADD) begin
          state_next = add_full ? S_REPLY : S_ADD2;
        end else begin
          state_next = S_RM_START;
        end
      end
      S_ADD2: state_next = S_REPLY;
      S_RM_START, S_RM_SCAN, S_RM_SHIFT: begin
        if (side_done) begin
          state_next = side ? S_REPLY : S_RM_START;
        end else if (state == S_RM_START) begin
          state_next = S_RM_SCAN;
        end else if (state == S_RM_SCAN && match) begin
          state_next = S_RM_SHIFT;
        end
      end
      S_LIST: begin
        if (out_free && list_last) begin
          state_next = S_IDLE;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs: memory controls and result load
  always_comb begin
    cmd.ready = (state == S_IDLE);
    deg_re    = 1'b0;
    deg_raddr = cmd.first_vertex;
    deg_we    = 1'b0;
    deg_waddr = va;
    deg_wdata = deg_a + DEG_W'(1);
    nb_re     = 1'b0;
    nb_raddr  = {va, SLOT_W'(0)};
    nb_we     = 1'b0;
    nb_waddr  = {va, deg_a[SLOT_W-1:0]};
    nb_wdata  = {vb, wt};
    res_load  = 1'b0;
    ld_status = rstat;
    ld_has    = 1'b0;
    ld_peer   = '0;
    ld_weight = '0;
    ld_last   = 1'b1;
    unique case (state) inside
      S_IDLE: begin
        deg_re = cmd_fire;
      end
      S_DEG_A: begin
        deg_re    = 1'b1;
        deg_raddr = vb;
        nb_re     = (func_r == FN_NBR) && (deg_now != '0);
      end
      S_DEG_B: begin
        if (func_r == FN_ADD && !add_full) begin
          deg_we = 1'b1;
          nb_we  = 1'b1;
        end
      end
      S_ADD2: begin
        deg_we    = 1'b1;
        deg_waddr = vb;
        deg_wdata = deg_b + DEG_W'(1);
        nb_we     = 1'b1;
        nb_waddr  = {vb, deg_b[SLOT_W-1:0]};
        nb_wdata  = {va, wt};
      end
      S_RM_START: begin
        nb_re    = (cur_n != '0);
        nb_raddr = {cur_u, SLOT_W'(0)};
      end
      S_RM_SCAN, S_RM_SHIFT: begin
        nb_re     = more && (state == S_RM_SHIFT || !match || more);
        nb_raddr  = {cur_u, slot_inc[SLOT_W-1:0]};
        deg_waddr = cur_u;
        deg_wdata = cur_n - DEG_W'(1);
        deg_we    = !more && (state == S_RM_SHIFT || match);
        nb_waddr  = {cur_u, SLOT_W'(slot - DEG_W'(1))};
        nb_wdata  = nb_rdata;
        nb_we     = (state == S_RM_SHIFT);
      end
      S_LIST: begin
        nb_re     = out_free && !list_last;
        nb_raddr  = {va, slot_inc[SLOT_W-1:0]};
        res_load  = out_free;
        ld_status = ST_OK;
        ld_has    = 1'b1;
        ld_peer   = ent_peer;
        ld_weight = nb_rdata[WGT_W-1:0];
        ld_last   = list_last;
      end
      S_REPLY: begin
        res_load = out_free;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      dvalid    <= '0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      if (deg_we) begin
        dvalid[deg_waddr] <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (deg_re) begin
      dvalid_q <= dvalid[deg_raddr];
    end
    if (res_load) begin
      res_status <= ld_status;
      res_has    <= ld_has;
      res_peer   <= ld_peer;
      res_weight <= ld_weight;
      res_last   <= ld_last;
    end
    case (state) inside
      S_IDLE: begin
        if (cmd_fire) begin
          func_r <= func_t'(cmd.func);
          va     <= cmd.first_vertex;
          vb     <= cmd.second_vertex;
          wt     <= cmd.edge_weight;
          side   <= 1'b0;
          miss   <= 1'b0;
          rstat  <= in_bad ? ST_BAD_VERTEX : ST_SELF_LOOP;
        end
      end
      S_DEG_A: begin
        deg_a <= deg_now;
        slot  <= '0;
        rstat <= ST_OK;
      end
      S_DEG_B: begin
        deg_b <= deg_now;
        rstat <= add_full ? ST_FULL : ST_OK;
      end
      S_RM_START, S_RM_SCAN, S_RM_SHIFT: begin
        if (side_done) begin
          side  <= 1'b1;
          miss  <= miss | side_miss;
          rstat <= (miss | side_miss) ? ST_NOT_FOUND : ST_OK;
          slot  <= '0;
        end else if (state == S_RM_START) begin
          slot <= '0;
        end else begin
          slot <= slot_inc;
        end
      end
      S_LIST: begin
        if (out_free && !list_last) begin
          slot <= slot_inc;
        end
      end
      default: ;
    endcase
  end

  assign res.valid           = res_valid;
  assign res.status          = res_status;
  assign res.has_neighbor    = res_has;
  assign res.neighbor_vertex = res_peer;
  assign res.neighbor_weight = res_weight;
  assign res.last_result     = res_last;
endmodule

### rtl/undirected_adjacency_table.sv
// Top level of the undirected adjacency table: register port, sequencer and
// the two state memories. Depends on uat_pkg, uat_cmd_if, uat_res_if,
// uat_ram, uat_cfg, uat_ctrl.
//
//   port     | kind        | moves
//   ---------+-------------+------------------------------------------------
//   cmd      | valid/ready | command item: func, vertices, weight
//   res      | valid/ready | result item: status, neighbor entry, last mark
//   APB      | psel/penable| vertex_count at byte address 0
//
// One command item at a time. Remove scans and shifts both lists through the
// one neighbor memory port; a neighbor query returns one result item per
// entry, or a single item with no neighbor when the list is empty; a rejected
// item gets a single status item.
// Reset clears the degree valid flags at once, so every list reads empty.
// An untaken full result stalls the sequencer; cmd.ready is high only in idle.
module undirected_adjacency_table import uat_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  uat_cmd_if.sink           cmd,
  uat_res_if.source         res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  logic [VCNT_W-1:0]  vertex_count;

  // degree memory port wires
  logic               deg_we, deg_re;
  logic [VTX_W-1:0]   deg_waddr, deg_raddr;
  logic [DEG_W-1:0]   deg_wdata, deg_rdata;

  // neighbor memory port wires: entry = {peer, weight}
  logic               nb_we, nb_re;
  logic [NB_AW-1:0]   nb_waddr, nb_raddr;
  logic [ENTRY_W-1:0] nb_wdata, nb_rdata;

  uat_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .vertex_count (vertex_count)
  );

  // per-vertex entry count; unwritten rows are masked by valid flags
  uat_ram #(
    .DEPTH (MAX_VERTICES),
    .WIDTH (DEG_W)
  ) u_deg_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .re    (deg_re),
    .raddr (deg_raddr),
    .rdata (deg_rdata)
  );

  // neighbor lists, row = vertex, column = list slot
  uat_ram #(
    .DEPTH (NB_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_nb_ram (
    .clk   (clk),
    .we    (nb_we),
    .waddr (nb_waddr),
    .wdata (nb_wdata),
    .re    (nb_re),
    .raddr (nb_raddr),
    .rdata (nb_rdata)
  );

  uat_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .vertex_count (vertex_count),
    .cmd          (cmd),
    .res          (res),
    .deg_we       (deg_we),
    .deg_waddr    (deg_waddr),
    .deg_wdata    (deg_wdata),
    .deg_re       (deg_re),
    .deg_raddr    (deg_raddr),
    .deg_rdata    (deg_rdata),
    .nb_we        (nb_we),
    .nb_waddr     (nb_waddr),
    .nb_wdata     (nb_wdata),
    .nb_re        (nb_re),
    .nb_raddr     (nb_raddr),
    .nb_rdata     (nb_rdata)
  );
endmodule

### verif/tb.sv
// Self-checking bench for undirected_adjacency_table: directed and random command items,
// predicted in a shadow graph and checked item by item on the result channel.
// Depends on uat_pkg, uat_cmd_if, uat_res_if and the top level of the block.
`timescale 1ns / 1ps

module tb import uat_pkg::*;;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned LONG_HOLD     = 400;  // receiver hold-off, in cycles
  localparam int unsigned SETTLE_CYCLES = 64;   // longer than any item takes
  localparam int unsigned MAX_GAP       = 13;

  // func code 3 is not an operation; the block drops such items
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [VTX_W-1:0]        first_vertex;
    logic [VTX_W-1:0]        second_vertex;
    logic signed [WGT_W-1:0] edge_weight;
  } command_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic                    has_neighbor;
    logic [VTX_W-1:0]        neighbor_vertex;
    logic signed [WGT_W-1:0] neighbor_weight;
    logic                    last_result;
  } reply_t;

  typedef struct packed {
    logic [VTX_W-1:0]        peer;
    logic signed [WGT_W-1:0] weight;
  } list_entry_t;

  // Shadow copy of the graph plus the queue of result items still owed by the block.
  class graph_mirror;
    list_entry_t       lists [MAX_VERTICES][MAX_DEGREE];
    int unsigned       degree [MAX_VERTICES];
    logic [VCNT_W-1:0] vertex_limit;
    reply_t            awaited [$];
    int unsigned       mismatches;

    function new();
      vertex_limit = VCNT_RESET;
      mismatches   = 0;
      foreach (degree[i]) degree[i] = 0;
    endfunction

    function bit in_range(logic [VTX_W-1:0] v);
      return (int'(v) < int'(vertex_limit)) && (int'(v) < MAX_VERTICES);
    endfunction

    function void owe(status_t st, logic has, logic [VTX_W-1:0] peer,
                      logic signed [WGT_W-1:0] w, logic last);
      reply_t r;
      r.status          = st;
      r.has_neighbor    = has;
      r.neighbor_vertex = peer;
      r.neighbor_weight = w;
      r.last_result     = last;
      awaited = {awaited, r};
    endfunction

    // Take out the first entry of list u that points at p; later entries move up.
    function bit unlink(int unsigned u, logic [VTX_W-1:0] p);
      int unsigned n;
      n = degree[u];
      for (int unsigned i = 0; i < n; i++) begin
        if (lists[u][i].peer == p) begin
          for (int unsigned j = i; j + 1 < n; j++) lists[u][j] = lists[u][j + 1];
          degree[u] = n - 1;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_command(command_t c);
      int unsigned u, v, n;
      bit          hit_u, hit_v;
      u = c.first_vertex;
      v = c.second_vertex;
      case (c.func) inside
        FN_ADD, FN_REM: begin
          if (!in_range(c.first_vertex) || !in_range(c.second_vertex)) begin
            owe(ST_BAD_VERTEX, 1'b0, '0, '0, 1'b1);
          end else if (u == v) begin
            owe(ST_SELF_LOOP, 1'b0, '0, '0, 1'b1);
          end else if (c.func == FN_ADD) begin
            if (degree[u] >= MAX_DEGREE || degree[v] >= MAX_DEGREE) begin
              owe(ST_FULL, 1'b0, '0, '0, 1'b1);
            end else begin
              lists[u][degree[u]].peer   = c.second_vertex;
              lists[u][degree[u]].weight = c.edge_weight;
              degree[u]++;
              lists[v][degree[v]].peer   = c.first_vertex;
              lists[v][degree[v]].weight = c.edge_weight;
              degree[v]++;
              owe(ST_OK, 1'b0, '0, '0, 1'b1);
            end
          end else begin
            // both sides are tried; a one-sided hit stays removed
            hit_u = unlink(u, c.second_vertex);
            hit_v = unlink(v, c.first_vertex);
            if (hit_u && hit_v) owe(ST_OK, 1'b0, '0, '0, 1'b1);
            else                owe(ST_NOT_FOUND, 1'b0, '0, '0, 1'b1);
          end
        end
        FN_NBR: begin
          n = degree[u];
          if (!in_range(c.first_vertex)) begin
            owe(ST_BAD_VERTEX, 1'b0, '0, '0, 1'b1);
          end else if (n == 0) begin
            owe(ST_OK, 1'b0, '0, '0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < n; i++)
              owe(ST_OK, 1'b1, lists[u][i].peer, lists[u][i].weight, i + 1 == n);
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result item with none expected: expected none, got status %0d",
                 $time, got.status);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("has_neighbor", want.has_neighbor, got.has_neighbor);
      compare_field("neighbor_vertex", want.neighbor_vertex, got.neighbor_vertex);
      compare_field("neighbor_weight", want.neighbor_weight, got.neighbor_weight);
      compare_field("last_result", want.last_result, got.last_result);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  uat_cmd_if cmd_ch ();
  uat_res_if res_ch ();

  undirected_adjacency_table dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  graph_mirror mirror = new();

  // Idle control shared by both sides: no_idle gives a stretch of back-to-back
  // items; hold_off_due asks the receiver for one long stall.
  bit no_idle      = 1'b0;
  bit hold_off_due = 1'b0;

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random gaps with ready low, then ready high until an item
  // is taken. Each taken item is checked against the oldest expectation.
  initial begin : result_sink
    int unsigned gap;
    reply_t      got;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_off_due) begin
        // long stall: the block fills up and must push back on cmd
        hold_off_due = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        gap = draw_gap();
        if (gap > 0) begin
          res_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      got.status          = res_ch.status;
      got.has_neighbor    = res_ch.has_neighbor;
      got.neighbor_vertex = res_ch.neighbor_vertex;
      got.neighbor_weight = res_ch.neighbor_weight;
      got.last_result     = res_ch.last_result;
      mirror.check_reply(got);
    end
  end

  function automatic command_t make_cmd(logic [FUNC_W-1:0] f, int unsigned a,
                                        int unsigned b, logic [WGT_W-1:0] w);
    command_t c;
    c.func          = f;
    c.first_vertex  = VTX_W'(a);
    c.second_vertex = VTX_W'(b);
    c.edge_weight   = w;
    return c;
  endfunction

  // Called right after a rising edge. valid is only lowered when a gap follows,
  // so back-to-back items keep it high without a low/high pair in one step.
  task automatic send_cmd(command_t c);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.func          <= c.func;
    cmd_ch.first_vertex  <= c.first_vertex;
    cmd_ch.second_vertex <= c.second_vertex;
    cmd_ch.edge_weight   <= c.edge_weight;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    mirror.note_command(c);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_vertex_count(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(4 * REG_VERTEX_COUNT);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mirror.vertex_limit = value[VCNT_W-1:0];
  endtask

  // Stop offering, wait for every owed result, then let a dropped item
  // (unused func) finish inside the block before touching the register.
  task automatic finish_phase();
    cmd_ch.valid <= 1'b0;
    while (mirror.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [VTX_W-1:0] pick_vertex(int unsigned span);
    if ($urandom_range(0, 9) < 8) return VTX_W'($urandom_range(0, span - 1));
    return VTX_W'($urandom_range(0, MAX_VERTICES - 1));
  endfunction

  // Mostly well-formed work: adds, removes and queries among valid vertices,
  // removes mostly at existing edges; the rest is out-of-range vertices and junk func.
  function automatic command_t random_cmd(int unsigned vcount);
    command_t    c;
    int unsigned span, pick, d;
    span = (vcount == 0) ? MAX_VERTICES : ((vcount > MAX_VERTICES) ? MAX_VERTICES : vcount);
    pick = $urandom_range(0, 99);
    c.first_vertex  = pick_vertex(span);
    c.second_vertex = pick_vertex(span);
    c.edge_weight   = $urandom;
    if (pick < 5) begin
      c.func = FN_UNUSED;
    end else if (pick < 50) begin
      c.func = FN_ADD;
    end else if (pick < 78) begin
      c.func = FN_REM;
      d = mirror.degree[c.first_vertex];
      if (d > 0 && $urandom_range(0, 9) < 7)
        c.second_vertex = mirror.lists[c.first_vertex][$urandom_range(0, d - 1)].peer;
    end else begin
      c.func = FN_NBR;
    end
    return c;
  endfunction

  task automatic random_phase(int unsigned vcount, int unsigned items, bit quiet, bit hold);
    command_t    c;
    int unsigned counted;
    write_vertex_count(vcount);
    no_idle = quiet;
    if (hold) hold_off_due = 1'b1;
    counted = 0;
    while (counted < items) begin
      c = random_cmd(vcount);
      send_cmd(c);
      // dropped items do not count toward the phase
      if (c.func inside {FN_ADD, FN_REM, FN_NBR}) counted++;
    end
    finish_phase();
    no_idle = 1'b0;
  endtask

  initial begin : stimulus
    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    cmd_ch.valid         <= 1'b0;
    cmd_ch.func          <= FN_ADD;
    cmd_ch.first_vertex  <= '0;
    cmd_ch.second_vertex <= '0;
    cmd_ch.edge_weight   <= '0;
    res_ch.ready         <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: full vertex range, weight extremes, every operation.
    write_vertex_count(MAX_VERTICES);
    send_cmd(make_cmd(FN_NBR, 0, 0, '0));                  // empty list
    send_cmd(make_cmd(FN_ADD, 0, 63, 32'h8000_0000));      // most negative weight
    send_cmd(make_cmd(FN_ADD, 63, 0, 32'h7FFF_FFFF));      // duplicate edge, max weight
    send_cmd(make_cmd(FN_NBR, 63, 0, '0));
    send_cmd(make_cmd(FN_ADD, 5, 5, '1));                  // self loop
    send_cmd(make_cmd(FN_UNUSED, 63, 63, '1));             // dropped, no result
    send_cmd(make_cmd(FN_REM, 0, 63, '0));                 // takes the first copy only
    send_cmd(make_cmd(FN_REM, 1, 2, '0));                  // edge not present
    // vertex 0 still holds one entry; fill it to the limit
    for (int unsigned k = 1; k < MAX_DEGREE; k++)
      send_cmd(make_cmd(FN_ADD, 0, k, $urandom));
    send_cmd(make_cmd(FN_ADD, 0, 20, $urandom));           // full on the first side
    send_cmd(make_cmd(FN_ADD, 21, 0, $urandom));           // full on the second side
    send_cmd(make_cmd(FN_NBR, 0, 0, '0));                  // longest stream
    send_cmd(make_cmd(FN_REM, 0, 63, '0));
    finish_phase();

    // Single vertex in use: everything but vertex 0 is out of range.
    write_vertex_count(1);
    send_cmd(make_cmd(FN_ADD, 3, 0, $urandom));
    send_cmd(make_cmd(FN_NBR, 1, 0, '0));
    send_cmd(make_cmd(FN_ADD, 0, 0, $urandom));
    finish_phase();

    // Random phases over several vertex counts, zero and above-range among them.
    random_phase(8, 30, 1'b0, 1'b1);
    random_phase(MAX_VERTICES, 25, 1'b1, 1'b0);
    random_phase(2, 20, 1'b0, 1'b0);                       // one edge pair: lists fill
    random_phase(127, 15, 1'b0, 1'b0);
    random_phase(3, 15, 1'b0, 1'b0);
    random_phase(0, 8, 1'b0, 1'b0);
    random_phase(1, 10, 1'b0, 1'b0);

    if (mirror.mismatches == 0 && mirror.awaited.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
